[rtl/dara_pkg.sv]
// Shared constants for the difference array range add unit.
// Holds store sizes, field widths and the item kind codes.
// No dependencies.
package dara_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int LEN_W        = ADDR_W + 1;
  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int INDEX_W      = 10;
  localparam int CFG_W        = 11;
  localparam int LEN_RESET    = 1024;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMIT   = 2'd2;

endpackage

[rtl/dara_in_if.sv]
// Input channel of the difference array range add unit.
// Carries valid, ready and one input item; depends on dara_pkg.
interface dara_in_if;
  import dara_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [DATA_W-1:0]  value;
  logic [INDEX_W-1:0]        left_index;
  logic [INDEX_W-1:0]        right_index;

  modport source (output valid, kind, value, left_index, right_index, input ready);
  modport sink   (input valid, kind, value, left_index, right_index, output ready);
endinterface

[rtl/dara_out_if.sv]
// Result channel of the difference array range add unit.
// Carries valid, ready and one result item; depends on dara_pkg.
interface dara_out_if;
  import dara_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  result_value;
  logic [INDEX_W-1:0]        position;
  logic                      last;

  modport source (output valid, result_value, position, last, input ready);
  modport sink   (input valid, result_value, position, last, output ready);
endinterface

[rtl/difference_array_range_add_unit.sv]
// Top level of the difference array range add unit: sequencer plus element and
// difference stores. Depends on dara_pkg, dara_in_if, dara_out_if, dara_ram.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        kind, value, left_index, right_index
//   out_ch    out  valid/ready        result_value, position, last
//   cfg       in   cfg_wr_en          cfg_wr_data (array_length)
//
// An update does one read-modify-write pass on the left-hand entry, and a second
// when the right-hand entry is touched, through the single difference RAM port.
// Emit: a read of both stores, plus any wait for the output register to drain.
// After reset a clearing pass zeroes all MAX_ELEMENTS (1024) difference store
// entries with in_ch.ready low. A pending result holds in the output register
// while the next item is taken.
module difference_array_range_add_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [dara_pkg::CFG_W-1:0]   cfg_wr_data,
  dara_in_if.sink                      in_ch,
  dara_out_if.source                   out_ch
);
  import dara_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_UPD_WR_L, ST_UPD_RD_R, ST_UPD_WR_R, ST_EMIT
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    array_length;
  logic [LEN_W-1:0]    active_len;
  logic [ADDR_W-1:0]   clr_addr;
  logic [LEN_W-1:0]    load_count;
  logic [LEN_W-1:0]    emit_cursor;
  logic [DATA_W-1:0]   running_sum;
  logic [ADDR_W-1:0]   upd_left;
  logic [ADDR_W-1:0]   upd_right1;
  logic                upd_sub;
  logic [DATA_W-1:0]   upd_value;

  logic                out_valid;
  logic [DATA_W-1:0]   out_value;
  logic [INDEX_W-1:0]  out_position;
  logic                out_last;

  logic                accept;
  logic                upd_ok;
  logic [LEN_W-1:0]    right_plus1;
  logic                emit_ok;
  logic                out_free;
  logic [DATA_W-1:0]   sum_next;

  logic                diff_en, diff_we;
  logic [ADDR_W-1:0]   diff_addr;
  logic [DATA_W-1:0]   diff_wdata, diff_rdata;
  logic                elem_en, elem_we;
  logic [ADDR_W-1:0]   elem_addr;
  logic [DATA_W-1:0]   elem_rdata;

  always_comb begin
    if (array_length == '0) begin
      active_len = LEN_W'(1);
    end else if (LEN_W'(array_length) > LEN_W'(MAX_ELEMENTS)) begin
      active_len = LEN_W'(MAX_ELEMENTS);
    end else begin
      active_len = LEN_W'(array_length);
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign right_plus1 = LEN_W'(in_ch.right_index) + LEN_W'(1);
  assign upd_ok      = (in_ch.left_index <= in_ch.right_index) &&
                       (LEN_W'(in_ch.right_index) < active_len);
  assign emit_ok     = emit_cursor < active_len;
  assign out_free    = !out_valid || out_ch.ready;
  assign sum_next    = running_sum + diff_rdata;

  always_comb begin
    diff_en    = 1'b0;
    diff_we    = 1'b0;
    diff_addr  = upd_left;
    diff_wdata = '0;
    elem_en    = 1'b0;
    elem_we    = 1'b0;
    elem_addr  = emit_cursor[ADDR_W-1:0];
    case (state)
      ST_CLEAR: begin
        diff_en   = 1'b1;
        diff_we   = 1'b1;
        diff_addr = clr_addr;
      end
      ST_IDLE: begin
        if (accept && in_ch.kind == KIND_UPDATE && upd_ok) begin
          diff_en   = 1'b1;
          diff_addr = ADDR_W'(in_ch.left_index);
        end else if (accept && in_ch.kind == KIND_EMIT && emit_ok) begin
          diff_en   = 1'b1;
          diff_addr = emit_cursor[ADDR_W-1:0];
          elem_en   = 1'b1;
        end else if (accept && in_ch.kind == KIND_LOAD && load_count < active_len) begin
          elem_en   = 1'b1;
          elem_we   = 1'b1;
          elem_addr = load_count[ADDR_W-1:0];
        end
      end
      ST_UPD_WR_L: begin
        diff_en    = 1'b1;
        diff_we    = 1'b1;
        diff_addr  = upd_left;
        diff_wdata = diff_rdata + upd_value;
      end
      ST_UPD_RD_R: begin
        diff_en   = 1'b1;
        diff_addr = upd_right1;
      end
      ST_UPD_WR_R: begin
        diff_en    = 1'b1;
        diff_we    = 1'b1;
        diff_addr  = upd_right1;
        diff_wdata = diff_rdata - upd_value;
      end
      ST_EMIT: begin
        diff_en   = out_free;
        diff_we   = 1'b1;
        diff_addr = emit_cursor[ADDR_W-1:0];
      end
      default: begin
        diff_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      array_length <= CFG_W'(LEN_RESET);
      clr_addr     <= '0;
      load_count   <= '0;
      emit_cursor  <= '0;
      running_sum  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        array_length <= cfg_wr_data;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MAX_ELEMENTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (in_ch.kind)
              KIND_LOAD: begin
                if (load_count < active_len) begin
                  load_count <= load_count + LEN_W'(1);
                end
              end
              KIND_UPDATE: begin
                if (upd_ok) begin
                  upd_left   <= ADDR_W'(in_ch.left_index);
                  upd_right1 <= right_plus1[ADDR_W-1:0];
                  upd_sub    <= right_plus1 < active_len;
                  upd_value  <= in_ch.value;
                  state      <= ST_UPD_WR_L;
                end
              end
              KIND_EMIT: begin
                if (emit_ok) begin
                  state <= ST_EMIT;
                end else begin
                  emit_cursor <= '0;
                  running_sum <= '0;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_UPD_WR_L: begin
          state <= upd_sub ? ST_UPD_RD_R : ST_IDLE;
        end
        ST_UPD_RD_R: begin
          state <= ST_UPD_WR_R;
        end
        ST_UPD_WR_R: begin
          state <= ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_value    <= elem_rdata + sum_next;
            out_position <= INDEX_W'(emit_cursor[ADDR_W-1:0]);
            out_last     <= emit_cursor == active_len - LEN_W'(1);
            if (emit_cursor == active_len - LEN_W'(1)) begin
              emit_cursor <= '0;
              running_sum <= '0;
              load_count  <= '0;
            end else begin
              emit_cursor <= emit_cursor + LEN_W'(1);
              running_sum <= sum_next;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_value = out_value;
  assign out_ch.position     = out_position;
  assign out_ch.last         = out_last;

  dara_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_diff_ram (
    .clk   (clk),
    .en    (diff_en),
    .we    (diff_we),
    .addr  (diff_addr),
    .wdata (diff_wdata),
    .rdata (diff_rdata)
  );

  dara_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .en    (elem_en),
    .we    (elem_we),
    .addr  (elem_addr),
    .wdata (in_ch.value),
    .rdata (elem_rdata)
  );

endmodule

[rtl/dara_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// Read data holds until the next read. No dependencies.
module dara_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[sim/tb_difference_array_range_add_unit.sv]
// Self-checking testbench for difference_array_range_add_unit: loads, range updates and
// emits are driven through dara_in_if, results are checked on dara_out_if against a
// cycle-free predictor of the difference store. Depends on dara_pkg and the RTL.
module tb_difference_array_range_add_unit;
  import dara_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEMS_PER_PHASE = 175;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [INDEX_W-1:0]       left_index;
    logic [INDEX_W-1:0]       right_index;
  } range_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [INDEX_W-1:0]       position;
    logic                     last;
  } element_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  dara_in_if  in_ch ();
  dara_out_if out_ch ();

  difference_array_range_add_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  range_op_t       queued_ops [$];
  element_result_t expected_elements [$];
  int              fail_count = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int unsigned     cycle_count = 0;
  logic            stall_kick = 1'b0;
  int              stall_left;

  // predictor state
  logic [CFG_W-1:0]         length_cfg;
  logic signed [DATA_W-1:0] element_mem [0:MAX_ELEMENTS-1];
  logic signed [DATA_W-1:0] diff_mem [0:MAX_ELEMENTS-1];
  int                       load_ptr;
  int                       emit_ptr;
  logic signed [DATA_W-1:0] run_sum;

  // stimulus bookkeeping
  int stim_count = 0;
  int gen_len;
  int gen_loads;
  int gen_cursor;
  bit written_mask [0:MAX_ELEMENTS-1];
  bit force_len = 1'b0;

  function automatic int eff_len(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_ELEMENTS) return MAX_ELEMENTS;
    return int'(raw);
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic apply_range_op(input range_op_t op);
    int len;
    int l;
    int r;
    element_result_t res;
    len = eff_len(length_cfg);
    l = int'(op.left_index);
    r = int'(op.right_index);
    case (op.kind)
      KIND_LOAD: begin
        if (load_ptr < len) begin
          element_mem[load_ptr] = op.value;
          load_ptr++;
        end
      end
      KIND_UPDATE: begin
        if (l <= r && r < len) begin
          diff_mem[l] = diff_mem[l] + op.value;
          if (r + 1 < len) diff_mem[r+1] = diff_mem[r+1] - op.value;
        end
      end
      KIND_EMIT: begin
        if (emit_ptr >= len) begin
          emit_ptr = 0;
          run_sum = '0;
        end else begin
          run_sum = run_sum + diff_mem[emit_ptr];
          diff_mem[emit_ptr] = '0;
          res.result_value = element_mem[emit_ptr] + run_sum;
          res.position = emit_ptr[INDEX_W-1:0];
          res.last = (emit_ptr == len - 1);
          expected_elements.push_back(res);
          if (res.last) begin
            emit_ptr = 0;
            run_sum = '0;
            load_ptr = 0;
          end else begin
            emit_ptr++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver: predict on each transfer, then offer the next queued op
  always @(posedge clk) begin
    range_op_t cur;
    range_op_t nxt;
    logic      taken;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      taken = in_ch.valid && in_ch.ready;
      if (taken) begin
        cur.kind = in_ch.kind;
        cur.value = in_ch.value;
        cur.left_index = in_ch.left_index;
        cur.right_index = in_ch.right_index;
        apply_range_op(cur);
      end
      if (!in_ch.valid || taken) begin
        if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_ops.pop_front();
          in_ch.kind <= nxt.kind;
          in_ch.value <= nxt.value;
          in_ch.left_index <= nxt.left_index;
          in_ch.right_index <= nxt.right_index;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest expected element
  always @(posedge clk) begin
    element_result_t got;
    element_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_value = out_ch.result_value;
        got.position = out_ch.position;
        got.last = out_ch.last;
        if (expected_elements.size() == 0) begin
          report_failure($sformatf("unexpected result: value %0d position %0d last %0b",
                                   got.result_value, got.position, got.last));
        end else begin
          want = expected_elements.pop_front();
          if (got.result_value !== want.result_value || got.position !== want.position ||
              got.last !== want.last)
            report_failure($sformatf({"result mismatch: value exp %0d got %0d, ",
                                      "position exp %0d got %0d, last exp %0b got %0b"},
              want.result_value, got.result_value, want.position, got.position,
              want.last, got.last));
        end
      end
      out_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_kick) begin
      stall_left <= 400;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return 11'd1;
    if (r < 9) return 11'd1024;
    if (r < 10) return 11'd2047;
    if (r < 11) return CFG_W'($urandom_range(1025, 2046));
    if (r < 25) return CFG_W'($urandom_range(13, 40));
    return CFG_W'($urandom_range(2, 12));
  endfunction

  function automatic bit emit_ok();
    return gen_cursor >= gen_len || written_mask[gen_cursor];
  endfunction

  task automatic push_item(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v,
                           input int l, input int r);
    range_op_t op;
    op.kind = k;
    op.value = v;
    op.left_index = l[INDEX_W-1:0];
    op.right_index = r[INDEX_W-1:0];
    queued_ops.push_back(op);
    if (k != KIND_UNUSED) stim_count++;
    case (k)
      KIND_LOAD: begin
        if (gen_loads < gen_len) begin
          written_mask[gen_loads] = 1'b1;
          gen_loads++;
        end
      end
      KIND_EMIT: begin
        if (gen_cursor >= gen_len) begin
          gen_cursor = 0;
        end else if (gen_cursor == gen_len - 1) begin
          gen_cursor = 0;
          gen_loads = 0;
        end else begin
          gen_cursor++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_update(input bit fits);
    int l;
    int r;
    if (fits) begin
      l = $urandom_range(gen_len - 1, 0);
      r = ($urandom_range(3) == 0) ? gen_len - 1 : $urandom_range(gen_len - 1, l);
    end else if (gen_len < MAX_ELEMENTS && $urandom_range(1) == 1) begin
      r = $urandom_range(MAX_ELEMENTS - 1, gen_len);
      l = $urandom_range(r, 0);
    end else begin
      l = $urandom_range(MAX_ELEMENTS - 1, 1);
      r = $urandom_range(l - 1, 0);
    end
    push_item(KIND_UPDATE, rand_word(), l, r);
  endtask

  task automatic settle();
    while (queued_ops.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_elements.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    settle();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    length_cfg = v;
    gen_len = eff_len(v);
  endtask

  task automatic full_pass();
    while (gen_loads < gen_len) begin
      push_item(KIND_LOAD, rand_word(), 0, 0);
      if ($urandom_range(19) == 0) push_item(KIND_UNUSED, $urandom, $urandom, $urandom);
    end
    repeat ($urandom_range(6)) push_update($urandom_range(4) != 0);
    do begin
      if (!emit_ok()) break;
      push_item(KIND_EMIT, $urandom, $urandom, $urandom);
      if ($urandom_range(9) == 0) push_update(1'b1);
    end while (gen_cursor != 0);
  endtask

  task automatic run_episode();
    int k;
    if (force_len || $urandom_range(99) < 70) write_length(pick_length());
    force_len = 1'b0;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(10, 3)) begin
        k = $urandom_range(3);
        if (k == KIND_EMIT && !emit_ok()) k = KIND_UNUSED;
        if ($urandom_range(1) == 1)
          push_item(k[KIND_W-1:0], $urandom, $urandom, $urandom);
        else
          push_item(k[KIND_W-1:0], rand_word(), $urandom_range(gen_len),
                    $urandom_range(gen_len));
      end
    end else if (gen_len > 64) begin
      // partial pass only at large lengths; a new length write follows
      repeat ($urandom_range(6, 2)) push_item(KIND_LOAD, rand_word(), 0, 0);
      push_item(KIND_UPDATE, rand_word(), $urandom_range(gen_len - 1), gen_len - 1);
      repeat (2) push_update($urandom_range(3) != 0);
      repeat ($urandom_range(4, 1)) if (emit_ok()) push_item(KIND_EMIT, $urandom, 0, 0);
      force_len = 1'b1;
    end else begin
      full_pass();
    end
  endtask

  initial begin
    int target;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.value = '0;
    in_ch.left_index = '0;
    in_ch.right_index = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      element_mem[i] = '0;
      diff_mem[i] = '0;
      written_mask[i] = 1'b0;
    end
    length_cfg = 11'd1024;
    load_ptr = 0;
    emit_ptr = 0;
    run_sum = '0;
    gen_len = MAX_ELEMENTS;
    gen_loads = 0;
    gen_cursor = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, dropped and edge updates, lowered length mid pass
    write_length(11'd2047);
    push_item(KIND_LOAD, 32'h8000_0000, 0, 0);
    push_item(KIND_LOAD, 32'h7fff_ffff, 0, 0);
    push_item(KIND_LOAD, 32'hffff_ffff, 0, 0);
    push_item(KIND_UPDATE, 32'd1, 0, 1023);
    push_item(KIND_UPDATE, 32'h7fff_ffff, 1, 2);
    push_item(KIND_UPDATE, 32'd7, 5, 4);
    push_item(KIND_UNUSED, 32'hffff_ffff, 1023, 1023);
    repeat (3) push_item(KIND_EMIT, 32'd0, 0, 0);
    write_length(11'd2);
    push_item(KIND_LOAD, 32'h1234_5678, 0, 0);
    push_item(KIND_UPDATE, 32'd9, 0, 2);
    push_item(KIND_UPDATE, 32'd9, 0, 1023);
    repeat (3) push_item(KIND_EMIT, 32'd0, 0, 0);
    write_length(11'd0);
    push_item(KIND_LOAD, 32'd0, 0, 0);
    push_item(KIND_UPDATE, 32'hffff_ffff, 0, 0);
    repeat (2) push_item(KIND_EMIT, 32'd0, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 17 : 0;
      if (phase == 2) begin
        write_length(11'd32);
        stall_kick <= 1'b1;
        @(posedge clk);
        stall_kick <= 1'b0;
        full_pass();
      end
      target = stim_count + ITEMS_PER_PHASE;
      while (stim_count < target) run_episode();
    end

    settle();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && expected_elements.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
